// ===== rtl/ipa_pkg.sv =====
// Shared constants, types and helper functions of the padded ASCII integer formatter.
package ipa_pkg;

  // Fixed field widths of the ports
  localparam int MAG_W   = 32;
  localparam int FLD_W   = 6;
  localparam int RADIX_W = 2;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 4;

  // Sizing of the formatter
  localparam int VALUE_BITS = 32;
  localparam int MAX_PAD    = 63;

  // Digit counts per radix; 1233 / 4096 approximates log10(2) from below
  localparam int DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int MAX_DIGITS = (OCT_DIGITS > DEC_DIGITS) ? OCT_DIGITS : DEC_DIGITS;
  localparam int OCT_BITS   = 3 * MAX_DIGITS;
  localparam int HEX_BITS   = DIGIT_W * MAX_DIGITS;

  localparam int IDX_W  = $clog2(MAX_DIGITS);
  localparam int NDIG_W = $clog2(MAX_DIGITS + 1);
  localparam int LEN_W  = $clog2((2 ** FLD_W) + MAX_DIGITS + 2);
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);

  // Radix codes
  localparam logic [RADIX_W-1:0] RADIX_DEC = 2'd0;
  localparam logic [RADIX_W-1:0] RADIX_OCT = 2'd1;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SPACE    = 7'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS    = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO     = 7'h30;
  localparam logic [CHAR_W-1:0] CH_LETTER_A = 7'h41;

  typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  negative;
    logic [FLD_W-1:0]      min_width;
    logic [FLD_W-1:0]      min_digits;
    logic [RADIX_W-1:0]    radix_select;
  } ipa_req_t;

  typedef struct packed {
    digits_t           digits;
    logic [NDIG_W-1:0] ndig;
    logic              negative;
    logic [FLD_W-1:0]  min_width;
    logic [FLD_W-1:0]  min_digits;
  } ipa_conv_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    if (d < 4'd10) begin
      return CH_ZERO + CHAR_W'(d);
    end
    return CH_LETTER_A + CHAR_W'(d - 4'd10);
  endfunction

  function automatic logic [FLD_W-1:0] clamp_pad(input logic [FLD_W-1:0] v);
    if (int'(v) > MAX_PAD) begin
      return FLD_W'(MAX_PAD);
    end
    return v;
  endfunction

endpackage

// ===== rtl/ipa_if.sv =====
// Handshake channels of the formatter: number words in, character words out.
interface ipa_num_if;
  import ipa_pkg::*;
  logic               valid;
  logic               ready;
  logic [MAG_W-1:0]   magnitude;
  logic               negative;
  logic [FLD_W-1:0]   min_width;
  logic [FLD_W-1:0]   min_digits;
  logic [RADIX_W-1:0] radix_select;

  modport source (output valid, magnitude, negative, min_width, min_digits, radix_select,
                  input ready);
  modport sink   (input valid, magnitude, negative, min_width, min_digits, radix_select,
                  output ready);
endinterface

interface ipa_char_if;
  import ipa_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last_char;

  modport source (output valid, char_out, last_char, input ready);
  modport sink   (input valid, char_out, last_char, output ready);
endinterface

// ===== rtl/ipa_digit_conv.sv =====
// Digit converter: bit-serial double dabble for decimal, direct split for octal and hex.
module ipa_digit_conv import ipa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  ipa_req_t  req,
  output logic      idle,
  output logic      res_valid,
  input  logic      res_take,
  output ipa_conv_t res
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DABBLE = 2'd1;
  localparam logic [1:0] S_COUNT  = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]            state;
  logic [CNT_W-1:0]      cnt;
  logic [VALUE_BITS-1:0] shift;
  digits_t               digits;
  logic [NDIG_W-1:0]     ndig;
  logic                  negative;
  logic [FLD_W-1:0]      min_width;
  logic [FLD_W-1:0]      min_digits;

  digits_t               corrected;
  logic [HEX_BITS-1:0]   corr_flat;
  logic [OCT_BITS-1:0]   oct_bits;
  logic [HEX_BITS-1:0]   hex_bits;
  digits_t               oct_digits;
  digits_t               hex_digits;
  logic [NDIG_W-1:0]     ndig_next;
  logic                  bcd_ok;

  // Add three to every digit of five or more before the next shift
  always_comb begin
    bcd_ok = 1'b1;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      corrected[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
      if (digits[i] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  assign corr_flat = corrected;
  assign oct_bits  = OCT_BITS'(req.value);
  assign hex_bits  = HEX_BITS'(req.value);

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      oct_digits[i] = {1'b0, oct_bits[3*i +: 3]};
      hex_digits[i] = hex_bits[DIGIT_W*i +: DIGIT_W];
    end
  end

  // Highest non-zero digit; a zero value still prints one digit
  always_comb begin
    ndig_next = NDIG_W'(1);
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (digits[i] != '0) begin
        ndig_next = NDIG_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            negative   <= req.negative;
            min_width  <= clamp_pad(req.min_width);
            min_digits <= clamp_pad(req.min_digits);
            case (req.radix_select)
              RADIX_OCT: begin
                digits <= oct_digits;
                state  <= S_COUNT;
              end
              RADIX_HEX: begin
                digits <= hex_digits;
                state  <= S_COUNT;
              end
              default: begin
                digits <= '0;
                shift  <= req.value;
                cnt    <= CNT_W'(VALUE_BITS);
                state  <= S_DABBLE;
              end
            endcase
          end
        end
        S_DABBLE: begin
          digits <= {corr_flat[HEX_BITS-2:0], shift[VALUE_BITS-1]};
          shift  <= shift << 1;
          cnt    <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= S_COUNT;
          end
        end
        S_COUNT: begin
          ndig  <= ndig_next;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle          = (state == S_IDLE);
  assign res_valid     = (state == S_DONE);
  assign res.digits    = digits;
  assign res.ndig      = ndig;
  assign res.negative  = negative;
  assign res.min_width = min_width;
  assign res.min_digits = min_digits;

  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    state == S_DABBLE |-> bcd_ok)
    else $error("decimal digit out of range during conversion");

  a_ndig_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (ndig != '0) && (int'(ndig) <= MAX_DIGITS))
    else $error("digit count out of range");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> idle)
    else $error("conversion started while busy");

endmodule

// ===== rtl/ipa_char_seq.sv =====
// Character sequencer: spaces, sign, zeros, digits; a word per ready cycle to an output register.
module ipa_char_seq import ipa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              conv_valid,
  input  ipa_conv_t         conv,
  output logic              conv_take,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  digits_t           digits;
  logic [NDIG_W-1:0] ndig;
  logic [LEN_W-1:0]  mp;
  logic              negative;
  logic [LEN_W-1:0]  rem;

  logic [LEN_W-1:0]  ld_width;
  logic [LEN_W-1:0]  ld_prec;
  logic [LEN_W-1:0]  ld_ndig;
  logic [LEN_W-1:0]  ld_mp;
  logic [LEN_W-1:0]  ld_body;
  logic [LEN_W-1:0]  ld_total;
  logic [LEN_W-1:0]  rem_m1;
  logic [CHAR_W-1:0] char_next;
  logic              advance;

  // Digit span, then body with sign, then full field
  assign ld_width = LEN_W'(conv.min_width);
  assign ld_prec  = LEN_W'(conv.min_digits);
  assign ld_ndig  = LEN_W'(conv.ndig);
  assign ld_mp    = (ld_prec > ld_ndig) ? ld_prec : ld_ndig;
  assign ld_body  = ld_mp + LEN_W'(conv.negative);
  assign ld_total = (ld_width > ld_body) ? ld_width : ld_body;

  assign conv_take = conv_valid && (rem == '0);
  assign advance   = !out_valid || out_ready;
  assign rem_m1    = rem - LEN_W'(1);

  // Character at position rem, counted from the right end
  always_comb begin
    if (rem <= LEN_W'(ndig)) begin
      char_next = glyph(digits[rem_m1[IDX_W-1:0]]);
    end else if (rem <= mp) begin
      char_next = CH_ZERO;
    end else if (negative && (rem_m1 == mp)) begin
      char_next = CH_MINUS;
    end else begin
      char_next = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (conv_take) begin
        digits   <= conv.digits;
        ndig     <= conv.ndig;
        mp       <= ld_mp;
        negative <= conv.negative;
        rem      <= ld_total;
      end
      if (advance) begin
        if (rem != '0) begin
          out_valid <= 1'b1;
          out_char  <= char_next;
          out_last  <= (rem == LEN_W'(1));
          rem       <= rem_m1;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  a_more_after_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> rem != '0)
    else $error("word not marked last but nothing remains");

  a_load_nonempty: assert property (@(posedge clk) disable iff (rst)
    conv_take |=> rem != '0)
    else $error("number loaded with zero length");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (rem != '0) && !advance |=> rem == $past(rem))
    else $error("position moved while output stalled");

endmodule

// ===== rtl/integer_to_padded_ascii.sv =====
// Top level of the padded ASCII integer formatter.
// Formats one number word into printf-style ASCII: leading spaces up to min_width, a minus
// sign when negative is set, zeros up to min_digits, then the digits in decimal, octal or
// upper-case hex (radix_select 3 is taken as decimal). Width and precision are clamped to
// MAX_PAD. Every character leaves as its own word, one per cycle while the sink is ready,
// and the final one carries last_char. Conversion: a decimal number is loaded, runs a bit-serial
// double-dabble loop over all VALUE_BITS bits and then counts its digits; octal and hex are
// split into digits at load and go straight to the digit count. A number then enters the
// character sequencer, which sends its characters from left to right. The converter and the
// sequencer work on separate numbers, so the next number converts while the current one is
// still being sent, and the output register keeps a stalled word while the sequencer waits.
module integer_to_padded_ascii import ipa_pkg::*; (
  input logic        clk,
  input logic        rst,
  ipa_num_if.sink    num,
  ipa_char_if.source text
);

  ipa_req_t  req;
  ipa_conv_t conv;
  logic      conv_idle;
  logic      conv_valid;
  logic      conv_take;
  logic      start;

  // Take a new number word whenever the converter is free
  assign num.ready = conv_idle;
  assign start     = num.valid && num.ready;

  // Keep only the low VALUE_BITS bits of the magnitude
  assign req.value        = VALUE_BITS'(num.magnitude);
  assign req.negative     = num.negative;
  assign req.min_width    = num.min_width;
  assign req.min_digits   = num.min_digits;
  assign req.radix_select = num.radix_select;

  ipa_digit_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .idle      (conv_idle),
    .res_valid (conv_valid),
    .res_take  (conv_take),
    .res       (conv)
  );

  ipa_char_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .conv_valid (conv_valid),
    .conv       (conv),
    .conv_take  (conv_take),
    .out_valid  (text.valid),
    .out_ready  (text.ready),
    .out_char   (text.char_out),
    .out_last   (text.last_char)
  );

endmodule
